[rtl/pidbc_pkg.sv]
// pidbc_pkg: widths, register indexes, mode codes and limits of the pid balance controller
// no dependencies; imported by pid_balance_controller

package pidbc_pkg;

   localparam int SampleWidth  = 16;
   localparam int GainWidth    = 16;
   localparam int ModeWidth    = 2;
   localparam int ErrWidth     = 17;
   localparam int DiffWidth    = 18;
   localparam int ProdWidth    = 33;
   localparam int DiffProdWidth = 34;
   localparam int IntegWidth   = 34;
   localparam int StoreWidth   = 24;
   localparam int TermWidth    = 32;
   localparam int SumWidth     = 35;
   localparam int ReqDataWidth = 48;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 16;

   localparam logic [CsrAddrWidth-1:0] CSR_GAIN_P    = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_GAIN_I    = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_GAIN_D    = 2'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_LOOP_MODE = 2'd3;

   localparam logic [ModeWidth-1:0] MODE_HOLD  = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_GYRO  = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_DIFF  = 2'd2;

   localparam logic signed [IntegWidth-1:0] INT_THRESH_POS = 34'sd204800;
   localparam logic signed [IntegWidth-1:0] INT_THRESH_NEG = -34'sd204800;
   localparam logic signed [IntegWidth-1:0] INT_LIMIT_POS  = 34'sd4096000;
   localparam logic signed [IntegWidth-1:0] INT_LIMIT_NEG  = -34'sd4096000;

   localparam logic signed [TermWidth-1:0] TERM_MAX = 32'sh7fff_ffff;
   localparam logic signed [TermWidth-1:0] TERM_MIN = 32'sh8000_0000;

endpackage

[rtl/pid_balance_controller.sv]
// pid_balance_controller: fixed-point pid loop with integral clamp, one sample per transfer
// depends on pidbc_pkg
//
// usage:
//   req channel carries one sample per transfer: setpoint, measured and gyro_rate,
//   all signed Q11.4. rsp channel returns one drive word (signed Q19.12,
//   saturated) per sample, in order.
//   csr port writes gain_p, gain_i, gain_d (signed Q7.8) and loop_mode at
//   indexes 0 to 3; the user must write them only while the block is idle,
//   which the block itself does not enforce.
//   datapath: a sample enters the input register, the pid terms are formed in one
//   pass of logic (two 17x16, one 16x16 and one 18x16 multiply, integral add and
//   clamp, final sum and saturation) and the drive lands in the output register.
//   throughput: one sample per cycle while the receiver does not stall, set by
//   the single-pass datapath; the integral, previous error and derivative
//   registers update with each result.
//   when the receiver stalls, the output register holds its word and the input
//   register still takes one more sample; req_tready drops only when both are full.
//   reset: gains clear to zero, loop_mode goes to 2, integral, previous error
//   and stored derivative clear to zero and both channels empty.

module pid_balance_controller
   import pidbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ReqDataWidth-1:0]  req_tdata,   // setpoint, measured, gyro_rate
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [TermWidth-1:0]     rsp_tdata,   // drive
   input  logic                     csr_we,
   input  logic [CsrAddrWidth-1:0]  csr_addr,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   function automatic logic signed [TermWidth-1:0] sat_34(input logic signed [33:0] v);
      logic signed [TermWidth-1:0] r;
      if (v > 34'sh0_7fff_ffff) r = TERM_MAX;
      else if (v < -34'sh0_8000_0000) r = TERM_MIN;
      else r = v[TermWidth-1:0];
      return r;
   endfunction

   function automatic logic signed [TermWidth-1:0] sat_35(input logic signed [SumWidth-1:0] v);
      logic signed [TermWidth-1:0] r;
      if (v > 35'sh0_7fff_ffff) r = TERM_MAX;
      else if (v < -35'sh0_8000_0000) r = TERM_MIN;
      else r = v[TermWidth-1:0];
      return r;
   endfunction

   // configuration
   logic signed [GainWidth-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [ModeWidth-1:0]        loop_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         loop_mode_ff <= MODE_DIFF;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_GAIN_P:    gain_p_ff    <= csr_wdata;
            CSR_GAIN_I:    gain_i_ff    <= csr_wdata;
            CSR_GAIN_D:    gain_d_ff    <= csr_wdata;
            CSR_LOOP_MODE: loop_mode_ff <= csr_wdata[ModeWidth-1:0];
            default:       ;
         endcase
      end
   end

   // input register
   logic                          in_valid_ff;
   logic signed [SampleWidth-1:0] setpoint_ff, measured_ff, gyro_ff;
   logic                          out_valid_ff;
   logic [TermWidth-1:0]          drive_ff;
   logic                          advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         setpoint_ff <= req_tdata[15:0];
         measured_ff <= req_tdata[31:16];
         gyro_ff     <= req_tdata[47:32];
      end
   end

   // loop state
   logic signed [StoreWidth-1:0] integral_ff, integral_in;
   logic signed [ErrWidth-1:0]   prev_err_ff;
   logic signed [TermWidth-1:0]  deriv_ff, deriv_in;

   // datapath
   logic signed [ErrWidth-1:0]      err;
   logic signed [DiffWidth-1:0]     err_diff;
   logic signed [ProdWidth-1:0]     p_term, i_prod;
   logic signed [TermWidth-1:0]     gyro_prod;
   logic signed [DiffProdWidth-1:0] diff_prod;
   logic signed [IntegWidth-1:0]    integ_raw, integ_chk, integ_clamped;
   logic                            sign_flip, outside;
   logic signed [SumWidth-1:0]      total;
   logic signed [TermWidth-1:0]     drive_in;

   always_comb begin
      err       = ErrWidth'(setpoint_ff) - ErrWidth'(measured_ff);
      err_diff  = DiffWidth'(err) - DiffWidth'(prev_err_ff);
      p_term    = ProdWidth'(err) * ProdWidth'(gain_p_ff);
      i_prod    = ProdWidth'(err) * ProdWidth'(gain_i_ff);
      gyro_prod = TermWidth'(gyro_ff) * TermWidth'(gain_d_ff);
      diff_prod = DiffProdWidth'(err_diff) * DiffProdWidth'(gain_d_ff);
      integ_raw = IntegWidth'(integral_ff) + IntegWidth'(i_prod);

      case (loop_mode_ff)
         MODE_GYRO: deriv_in = gyro_prod;
         MODE_DIFF: deriv_in = sat_34(diff_prod);
         default:   deriv_in = deriv_ff;
      endcase

      outside   = (integ_raw > INT_THRESH_POS) || (integ_raw < INT_THRESH_NEG);
      sign_flip = (prev_err_ff < 0 && err > 0) || (prev_err_ff > 0 && err < 0);
      if (loop_mode_ff == MODE_DIFF && outside && sign_flip) integ_chk = '0;
      else integ_chk = integ_raw;

      if (integ_chk > INT_LIMIT_POS) integ_clamped = INT_LIMIT_POS;
      else if (integ_chk < INT_LIMIT_NEG) integ_clamped = INT_LIMIT_NEG;
      else integ_clamped = integ_chk;
      integral_in = integ_clamped[StoreWidth-1:0];

      total    = SumWidth'(p_term) + SumWidth'(integral_in) + SumWidth'(deriv_in);
      drive_in = sat_35(total);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         prev_err_ff <= '0;
         deriv_ff    <= '0;
      end else if (advance) begin
         integral_ff <= integral_in;
         prev_err_ff <= err;
         deriv_ff    <= deriv_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = drive_ff;

   // checks
   a_integral_bounded: assert property (@(posedge clock) disable iff (reset)
      (IntegWidth'(integral_ff) <= INT_LIMIT_POS) && (IntegWidth'(integral_ff) >= INT_LIMIT_NEG))
      else $error("integral outside clamp range");

   a_state_held: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(integral_ff) && $stable(prev_err_ff) && $stable(deriv_ff))
      else $error("loop state changed without a transfer");

   a_prev_err_tracks: assert property (@(posedge clock) disable iff (reset)
      advance |=> prev_err_ff == $past(err))
      else $error("previous error not taken from last sample");

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff)
      else $error("input blocked while a stage is free");

endmodule

[bench/pid_balance_controller_tb.sv]
// pid_balance_controller_tb: self-checking bench for the pid balance controller
// drives samples and register writes, predicts each drive word and compares it in order
// depends on pidbc_pkg and pid_balance_controller

module pid_balance_controller_tb;
   import pidbc_pkg::*;

   localparam logic [ModeWidth-1:0] MODE_SPARE = 2'd3;
   localparam int PhaseCount     = 9;
   localparam int PhaseSamples   = 225;
   localparam int HoldoffCycles  = 200;
   localparam int WatchdogLimit  = 5000;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic [CsrAddrWidth-1:0]  idx;
      logic [CsrDataWidth-1:0]  val;
      logic [ReqDataWidth-1:0]  data;
      bit                       known;
      logic [TermWidth-1:0]     drive;
   } plan_row_type;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [TermWidth-1:0]     rsp_tdata;
   logic                     csr_we      = 1'b0;
   logic [CsrAddrWidth-1:0]  csr_addr    = '0;
   logic [CsrDataWidth-1:0]  csr_wdata   = '0;

   // typed-in expectation travels with the sample
   bit                       tag_known   = 1'b0;
   logic [TermWidth-1:0]     tag_drive   = '0;

   // controller copy: registers and loop state
   logic signed [GainWidth-1:0] kp_cfg   = '0;
   logic signed [GainWidth-1:0] ki_cfg   = '0;
   logic signed [GainWidth-1:0] kd_cfg   = '0;
   logic [ModeWidth-1:0]        mode_cfg = MODE_DIFF;
   longint                      integ_acc = 0;
   longint                      last_err  = 0;
   longint                      d_hold    = 0;

   logic [TermWidth-1:0] drive_q[$];
   plan_row_type         plan_q[$];

   int send_idle_pct = 36;
   int recv_idle_pct = 49;
   int stalls_asked  = 0;
   int stalls_done   = 0;
   int fail_count    = 0;
   int samples_sent  = 0;
   int drives_checked = 0;
   int drives_saturated = 0;
   int settings_used = 0;
   int quiet_cycles  = 0;

   pid_balance_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint sat32(input longint v);
      if (v > longint'(TERM_MAX)) return longint'(TERM_MAX);
      if (v < longint'(TERM_MIN)) return longint'(TERM_MIN);
      return v;
   endfunction

   function automatic logic [TermWidth-1:0] predict_drive(input logic [ReqDataWidth-1:0] data);
      logic signed [SampleWidth-1:0] sp_f, ms_f, gy_f;
      longint sp, ms, gy, kp, ki, kd, err, pterm, integ;
      bit outside;
      sp_f = data[15:0];
      ms_f = data[31:16];
      gy_f = data[47:32];
      sp = sp_f;
      ms = ms_f;
      gy = gy_f;
      kp = kp_cfg;
      ki = ki_cfg;
      kd = kd_cfg;
      err = sp - ms;
      pterm = err * kp;
      integ = integ_acc + err * ki;
      if (mode_cfg == MODE_GYRO) begin
         d_hold = sat32(gy * kd);
      end else if (mode_cfg == MODE_DIFF) begin
         d_hold = sat32((err - last_err) * kd);
      end
      if (mode_cfg == MODE_DIFF) begin
         outside = (integ > longint'(INT_THRESH_POS)) || (integ < longint'(INT_THRESH_NEG));
         if (outside && ((last_err < 0 && err > 0) || (last_err > 0 && err < 0)))
            integ = 0;
      end
      last_err = err;
      if (integ > longint'(INT_LIMIT_POS))
         integ = longint'(INT_LIMIT_POS);
      else if (integ < longint'(INT_LIMIT_NEG))
         integ = longint'(INT_LIMIT_NEG);
      integ_acc = integ;
      return TermWidth'(sat32(pterm + integ_acc + d_hold));
   endfunction

   function automatic logic [ReqDataWidth-1:0] pack_sample(input int sp, input int ms, input int gy);
      return {16'(gy), 16'(ms), 16'(sp)};
   endfunction

   function automatic void add_reg(input logic [CsrAddrWidth-1:0] idx,
                                   input logic [CsrDataWidth-1:0] val);
      plan_row_type row;
      row = '{ROW_CSR, idx, val, '0, 1'b0, '0};
      plan_q.push_back(row);
   endfunction

   function automatic void add_sample(input int sp, input int ms, input int gy);
      plan_row_type row;
      row = '{ROW_SAMPLE, '0, '0, pack_sample(sp, ms, gy), 1'b0, '0};
      plan_q.push_back(row);
   endfunction

   function automatic void add_known(input int sp, input int ms, input int gy,
                                     input logic [TermWidth-1:0] drive);
      plan_row_type row;
      row = '{ROW_SAMPLE, '0, '0, pack_sample(sp, ms, gy), 1'b1, drive};
      plan_q.push_back(row);
   endfunction

   function automatic int rand_field();
      int r;
      r = $urandom_range(99);
      if (r < 45) return int'($urandom_range(511)) - 256;
      if (r < 85) return int'(16'($urandom()));
      case ($urandom_range(3))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   function automatic logic [GainWidth-1:0] pick_gain(input int style);
      case (style)
         0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         1: return 16'(int'($urandom_range(1023)) - 512);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_sample(input logic [ReqDataWidth-1:0] data, input bit known,
                              input logic [TermWidth-1:0] drive);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      tag_known  <= known;
      tag_drive  <= drive;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (drive_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrAddrWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_GAIN_P:    kp_cfg   = val;
         CSR_GAIN_I:    ki_cfg   = val;
         CSR_GAIN_D:    kd_cfg   = val;
         CSR_LOOP_MODE: mode_cfg = val[ModeWidth-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // receiver: random stalls, or a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (stalls_done != stalls_asked) begin
            rsp_tready <= 1'b0;
            repeat (HoldoffCycles) @(posedge clock);
            stalls_done++;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // scoreboard: check drive words, predict on each sample transfer
   always @(posedge clock) begin
      logic [TermWidth-1:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (drive_q.size() == 0) begin
               $error("drive: unexpected word %0d with nothing pending", $signed(rsp_tdata));
               fail_count++;
            end else begin
               want = drive_q.pop_front();
               if (rsp_tdata !== want) begin
                  $error("drive mismatch: expected %0d, actual %0d",
                         $signed(want), $signed(rsp_tdata));
                  fail_count++;
               end
               if (want == TERM_MAX || want == TERM_MIN) drives_saturated++;
               drives_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_drive(req_tdata);
            drive_q.push_back(tag_known ? tag_drive : want);
            samples_sent++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin : stimulus
      bit in_csr;
      int style;
      logic [ModeWidth-1:0] phase_mode [PhaseCount];
      phase_mode = '{MODE_DIFF, MODE_GYRO, MODE_DIFF, MODE_HOLD, MODE_DIFF,
                     MODE_SPARE, MODE_DIFF, MODE_GYRO, MODE_DIFF};

      // reset state: zero gains give zero drive
      add_known(100, -100, 5, '0);
      add_known(-32768, 32767, 32767, '0);
      // proportional extremes, derivative held
      add_reg(CSR_GAIN_P, 16'h7fff);
      add_reg(CSR_LOOP_MODE, {14'd0, MODE_HOLD});
      add_known(32767, -32768, 0, 32'sd2147385345);
      add_known(-32768, 32767, 0, -32'sd2147385345);
      add_known(0, 0, -1, '0);
      // gyro derivative, sum saturates both ways
      add_reg(CSR_GAIN_P, 16'h8000);
      add_reg(CSR_GAIN_D, 16'h8000);
      add_reg(CSR_LOOP_MODE, {14'd0, MODE_GYRO});
      add_known(-32768, 32767, -32768, TERM_MAX);
      add_known(32767, -32768, 32767, TERM_MIN);
      add_sample(100, 0, 0);
      // integral clamp, sign-change clear, zero error, threshold on unclamped sum
      add_reg(CSR_GAIN_P, 16'h0000);
      add_reg(CSR_GAIN_D, 16'h0000);
      add_reg(CSR_GAIN_I, 16'h7fff);
      add_reg(CSR_LOOP_MODE, {14'd0, MODE_DIFF});
      add_known(32767, -32768, 0, 32'sd4096000);
      add_known(-32768, 32767, 0, '0);
      add_sample(5, 5, 0);
      add_sample(1, 0, 0);
      add_sample(0, 1, 0);
      add_sample(7, 0, 0);
      add_sample(0, 6, 0);
      // held derivative under the spare mode code
      add_reg(CSR_GAIN_P, 16'd100);
      add_reg(CSR_GAIN_D, 16'h7fff);
      add_reg(CSR_GAIN_I, 16'h8000);
      add_reg(CSR_LOOP_MODE, {14'd0, MODE_GYRO});
      add_sample(0, 0, 1000);
      add_reg(CSR_LOOP_MODE, 16'hffff);
      add_sample(1000, -1000, 500);
      add_sample(-32768, 32767, -32768);
      // error-difference product saturates before it is stored
      add_reg(CSR_GAIN_P, 16'h0000);
      add_reg(CSR_GAIN_I, 16'h0000);
      add_reg(CSR_GAIN_D, 16'h8000);
      add_reg(CSR_LOOP_MODE, {14'd0, MODE_DIFF});
      add_sample(-32768, 32767, 0);
      add_sample(32767, -32768, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      in_csr = 1'b0;
      foreach (plan_q[i]) begin
         if (plan_q[i].kind == ROW_CSR) begin
            if (!in_csr) begin
               wait_idle();
               settings_used++;
            end
            write_reg(plan_q[i].idx, plan_q[i].val);
            in_csr = 1'b1;
         end else begin
            send_sample(plan_q[i].data, plan_q[i].known, plan_q[i].drive);
            in_csr = 1'b0;
         end
      end

      for (int ph = 0; ph < PhaseCount; ph++) begin
         wait_idle();
         case (ph / 3)
            0: begin send_idle_pct = 36; recv_idle_pct = 49; end
            1: begin send_idle_pct = 49; recv_idle_pct = 36; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         style = ph % 3;
         write_reg(CSR_GAIN_P, pick_gain(style));
         write_reg(CSR_GAIN_I, pick_gain(style));
         write_reg(CSR_GAIN_D, pick_gain(style));
         write_reg(CSR_LOOP_MODE, {14'($urandom()), phase_mode[ph]});
         settings_used++;
         for (int n = 0; n < PhaseSamples; n++) begin
            if ((ph == 1 || ph == 7) && n == 20) stalls_asked++;
            send_sample(pack_sample(rand_field(), rand_field(), rand_field()), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (drive_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d samples and %0d drive words (%0d saturated) over %0d register settings",
               samples_sent, drives_checked, drives_saturated, settings_used);
      $display("all loop modes with the spare code, gain extremes, stalls on both sides");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[files.f]
rtl/pidbc_pkg.sv
rtl/pid_balance_controller.sv
bench/pid_balance_controller_tb.sv
